// ===== rtl/dlwv_pkg.sv =====
`default_nettype none
package dlwv_pkg;

  localparam int LABEL_W     = 3;
  localparam int CLASS_W     = 4;
  localparam int THR_W       = 5;
  localparam int NUM_COUNTED = 7;

  localparam logic [THR_W-1:0]   THR_RESET   = 5'd13;
  localparam logic [LABEL_W-1:0] LABEL_NONE  = 3'd0;
  localparam logic [LABEL_W-1:0] LABEL_OTHER = 3'd7;
  localparam logic [CLASS_W-1:0] CLASS_LAST  = 4'd5;

  typedef struct packed {
    logic               has_box;
    logic               last;
    logic               area_neg;
    logic [LABEL_W-1:0] label;
  } s1_ctrl_t;

  function automatic logic [LABEL_W-1:0] class_to_label(input logic [CLASS_W-1:0] cls);
    logic [CLASS_W-1:0] inc;
    inc = cls + CLASS_W'(1);
    if (cls <= CLASS_LAST) begin
      return inc[LABEL_W-1:0];
    end
    return LABEL_OTHER;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/dlwv_in_stage.sv =====
`default_nettype none
module dlwv_in_stage #(
  parameter int COORD_BITS = 12
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              in_has_box,
  input  wire logic [dlwv_pkg::CLASS_W-1:0]      in_class_id,
  input  wire logic [COORD_BITS-1:0]             in_x_min,
  input  wire logic [COORD_BITS-1:0]             in_y_min,
  input  wire logic [COORD_BITS-1:0]             in_x_max,
  input  wire logic [COORD_BITS-1:0]             in_y_max,
  input  wire logic                              in_last_in_frame,
  input  wire logic                              s1_go,
  output logic                                   s1_valid,
  output dlwv_pkg::s1_ctrl_t                     s1_ctrl,
  output logic [2*COORD_BITS-1:0]                s1_area
);

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * COORD_BITS + 2;

  logic                     s1_valid_r, s1_valid_nxt;
  dlwv_pkg::s1_ctrl_t       s1_ctrl_r;
  logic [2*COORD_BITS-1:0]  s1_area_r;
  logic                     load;
  logic [DW-1:0]            dx, dy;
  logic signed [PW-1:0]     dx_w, dy_w, prod;

  assign in_stall = s1_valid_r && !s1_go;
  assign load     = in_valid && !in_stall;

  assign dx   = {1'b0, in_x_max} - {1'b0, in_x_min};
  assign dy   = {1'b0, in_y_max} - {1'b0, in_y_min};
  assign dx_w = {{(PW-DW){dx[DW-1]}}, dx};
  assign dy_w = {{(PW-DW){dy[DW-1]}}, dy};
  assign prod = dx_w * dy_w;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (load) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_ctrl_r.has_box  <= in_has_box;
      s1_ctrl_r.last     <= in_last_in_frame;
      s1_ctrl_r.area_neg <= prod[PW-1];
      s1_ctrl_r.label    <= dlwv_pkg::class_to_label(in_class_id);
      s1_area_r          <= prod[2*COORD_BITS-1:0];
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_ctrl  = s1_ctrl_r;
  assign s1_area  = s1_area_r;

endmodule
`default_nettype wire

// ===== rtl/dlwv_window.sv =====
`default_nettype none
module dlwv_window #(
  parameter int WINDOW_LEN = 20
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              push,
  input  wire logic [dlwv_pkg::LABEL_W-1:0]      push_label,
  input  wire logic [dlwv_pkg::THR_W-1:0]        threshold,
  output logic [dlwv_pkg::LABEL_W-1:0]           decision
);

  localparam int PTR_W  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int FILL_W = $clog2(WINDOW_LEN + 1);
  localparam int CNT_W  = $clog2(WINDOW_LEN + 1);

  logic [dlwv_pkg::LABEL_W-1:0] win_r [WINDOW_LEN];
  logic [FILL_W-1:0]            fill_r, fill_nxt;
  logic [PTR_W-1:0]             ptr_r, ptr_nxt;
  logic [CNT_W-1:0]             cnt_r   [dlwv_pkg::NUM_COUNTED];
  logic [CNT_W-1:0]             cnt_nxt [dlwv_pkg::NUM_COUNTED];
  logic                         full;
  logic [PTR_W-1:0]             wr_idx;
  logic [dlwv_pkg::LABEL_W-1:0] old_label;

  assign full      = (fill_r == FILL_W'(WINDOW_LEN));
  assign wr_idx    = full ? ptr_r : fill_r[PTR_W-1:0];
  assign old_label = win_r[ptr_r];

  always_comb begin
    fill_nxt = fill_r;
    ptr_nxt  = ptr_r;
    if (push) begin
      if (full) begin
        ptr_nxt = (ptr_r == PTR_W'(WINDOW_LEN - 1)) ? '0 : ptr_r + PTR_W'(1);
      end else begin
        fill_nxt = fill_r + FILL_W'(1);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < dlwv_pkg::NUM_COUNTED; i++) begin
      cnt_nxt[i] = cnt_r[i];
      if (push) begin
        if (full && old_label == dlwv_pkg::LABEL_W'(i) && cnt_r[i] != '0) begin
          cnt_nxt[i] = cnt_nxt[i] - CNT_W'(1);
        end
        if (push_label == dlwv_pkg::LABEL_W'(i)) begin
          cnt_nxt[i] = cnt_nxt[i] + CNT_W'(1);
        end
      end
    end
  end

  always_comb begin
    decision = dlwv_pkg::LABEL_NONE;
    for (int i = dlwv_pkg::NUM_COUNTED - 1; i >= 0; i--) begin
      if (dlwv_pkg::THR_W'(cnt_nxt[i]) > threshold) begin
        decision = dlwv_pkg::LABEL_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      ptr_r  <= '0;
      for (int i = 0; i < dlwv_pkg::NUM_COUNTED; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      fill_r <= fill_nxt;
      ptr_r  <= ptr_nxt;
      for (int i = 0; i < dlwv_pkg::NUM_COUNTED; i++) begin
        cnt_r[i] <= cnt_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      win_r[wr_idx] <= push_label;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/detection_label_window_vote_core.sv =====
`default_nettype none
// Channel  Direction  Handshake         Payload
// in       input      in_valid/stall    has_box, class_id, x_min, y_min, x_max, y_max, last
// out      output     out_valid/stall   decision, frame_label
// cfg      input      cfg_valid/ready   vote_threshold (cfg_data)
//
// One request per cycle while in_stall is low; a frame result passes from its last request
// through the input register (area multiply) and then the result register.
// Synchronous active-low reset clears the window fill, counts and threshold (13).
// A held result stalls the input only when the registered request also ends a frame or has no box.
module detection_label_window_vote_core #(
  parameter int WINDOW_LEN = 20,
  parameter int COORD_BITS = 12
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              in_has_box,
  input  wire logic [dlwv_pkg::CLASS_W-1:0]      in_class_id,
  input  wire logic [COORD_BITS-1:0]             in_x_min,
  input  wire logic [COORD_BITS-1:0]             in_y_min,
  input  wire logic [COORD_BITS-1:0]             in_x_max,
  input  wire logic [COORD_BITS-1:0]             in_y_max,
  input  wire logic                              in_last_in_frame,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [dlwv_pkg::LABEL_W-1:0]           out_decision,
  output logic [dlwv_pkg::LABEL_W-1:0]           out_frame_label,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [dlwv_pkg::THR_W-1:0]        cfg_data
);

  logic                         s1_valid, s1_go, produces, out_free, win, push;
  dlwv_pkg::s1_ctrl_t           s1_ctrl;
  logic [2*COORD_BITS-1:0]      s1_area;
  logic [2*COORD_BITS-1:0]      best_area_r, best_area_nxt;
  logic [dlwv_pkg::LABEL_W-1:0] best_label_r, best_label_nxt;
  logic [dlwv_pkg::LABEL_W-1:0] frame_label, decision;
  logic [dlwv_pkg::THR_W-1:0]   thr_r;
  logic                         out_valid_r, out_valid_nxt;
  logic [dlwv_pkg::LABEL_W-1:0] out_decision_r, out_frame_label_r;

  dlwv_in_stage #(
    .COORD_BITS(COORD_BITS)
  ) u_in_stage (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_has_box      (in_has_box),
    .in_class_id     (in_class_id),
    .in_x_min        (in_x_min),
    .in_y_min        (in_y_min),
    .in_x_max        (in_x_max),
    .in_y_max        (in_y_max),
    .in_last_in_frame(in_last_in_frame),
    .s1_go           (s1_go),
    .s1_valid        (s1_valid),
    .s1_ctrl         (s1_ctrl),
    .s1_area         (s1_area)
  );

  assign out_free    = !out_valid_r || !out_stall;
  assign produces    = !s1_ctrl.has_box || s1_ctrl.last;
  assign s1_go       = s1_valid && (!produces || out_free);
  assign push        = s1_go && produces;
  assign win         = s1_ctrl.has_box && !s1_ctrl.area_neg && (s1_area > best_area_r);
  assign frame_label = win ? s1_ctrl.label : best_label_r;

  always_comb begin
    best_area_nxt  = best_area_r;
    best_label_nxt = best_label_r;
    if (s1_go) begin
      if (produces) begin
        best_area_nxt  = '0;
        best_label_nxt = dlwv_pkg::LABEL_NONE;
      end else if (win) begin
        best_area_nxt  = s1_area;
        best_label_nxt = s1_ctrl.label;
      end
    end
  end

  dlwv_window #(
    .WINDOW_LEN(WINDOW_LEN)
  ) u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_label(frame_label),
    .threshold (thr_r),
    .decision  (decision)
  );

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (push) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_area_r  <= '0;
      best_label_r <= dlwv_pkg::LABEL_NONE;
      thr_r        <= dlwv_pkg::THR_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      best_area_r  <= best_area_nxt;
      best_label_r <= best_label_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_valid) begin
        thr_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_decision_r    <= decision;
      out_frame_label_r <= frame_label;
    end
  end

  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_decision    = out_decision_r;
  assign out_frame_label = out_frame_label_r;

endmodule
`default_nettype wire

// ===== rtl/dlwv_checker.sv =====
`default_nettype none
module dlwv_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_valid,
  input wire logic                         in_stall,
  input wire logic                         in_has_box,
  input wire logic                         out_valid,
  input wire logic                         out_stall,
  input wire logic [dlwv_pkg::LABEL_W-1:0] out_decision,
  input wire logic [dlwv_pkg::LABEL_W-1:0] out_frame_label
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_decision) && $stable(out_frame_label))
    else $error("stalled result changed");

  a_marker_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_has_box |=> ##1 out_valid)
    else $error("no result after empty-frame request");

  a_decision_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_decision != dlwv_pkg::LABEL_OTHER)
    else $error("decision out of range");

endmodule

bind detection_label_window_vote_core dlwv_checker u_dlwv_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_has_box     (in_has_box),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_decision   (out_decision),
  .out_frame_label(out_frame_label)
);
`default_nettype wire
